// File: hw/rtl/meter_frame_receiver_core_macros.svh
// assertion macros used by the frame receiver parser
`ifndef METER_FRAME_RECEIVER_CORE_MACROS_SVH
`define METER_FRAME_RECEIVER_CORE_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define MFR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define MFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/mfr_pkg.sv
// shared types, constants and codes of the meter frame receiver
package mfr_pkg;

    localparam int LEN_POS_DEF   = 10;
    localparam int MAX_FRAME_DEF = 256;
    localparam int BYTE_W        = 8;
    localparam int POS_W         = 8;
    localparam int TICK_W        = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'h68;
    localparam logic [BYTE_W-1:0] END_RESET     = 8'h16;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 16'd500;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        VERDICT_NONE     = 3'd0,
        VERDICT_GOOD     = 3'd1,
        VERDICT_SUM_BAD  = 3'd2,
        VERDICT_END_BAD  = 3'd3,
        VERDICT_TIMEOUT  = 3'd4,
        VERDICT_TOO_LONG = 3'd5
    } verdict_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SYNC    = 2'd0,
        REG_END     = 2'd1,
        REG_TIMEOUT = 2'd2
    } reg_index_t;

    typedef enum logic {
        ST_SYNC  = 1'b0,
        ST_FRAME = 1'b1
    } state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_value;
        logic [BYTE_W-1:0] end_value;
        logic [TICK_W-1:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [BYTE_W-1:0] rx_byte;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [POS_W-1:0]  position;
        logic              frame_start;
        logic              frame_end;
        verdict_t          verdict;
    } result_t;

endpackage

// File: hw/rtl/mfr_cfg_regs.sv
// configuration register bank of the meter frame receiver
module mfr_cfg_regs
    import mfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // writes are always taken outside reset
    assign cfg_ready = aresetn;

    // register select
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SYNC:    cfg_next.sync_value    = cfg_data[BYTE_W-1:0];
                REG_END:     cfg_next.end_value     = cfg_data[BYTE_W-1:0];
                REG_TIMEOUT: cfg_next.timeout_ticks = cfg_data[TICK_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_value    <= SYNC_RESET;
            cfg_reg.end_value     <= END_RESET;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: hw/rtl/mfr_in_reg.sv
// input register stage of the meter frame receiver
module mfr_in_reg
    import mfr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,
    input  logic [0:0]        s_tuser,
    input  logic              advance,
    output logic              item_valid,
    output item_t             item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // room when empty or when the held beat moves on this cycle
    assign s_tready = aresetn && (!valid_reg || advance);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        if (accept) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg.cmd     <= cmd_t'(s_tuser[0]);
            item_reg.rx_byte <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// File: hw/rtl/mfr_parser.sv
// frame tracking state and per-beat result logic
`include "meter_frame_receiver_core_macros.svh"

module mfr_parser
    import mfr_pkg::*;
#(
    parameter int LEN_POS   = LEN_POS_DEF,
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    step,
    input  item_t   item,
    output logic    res_valid,
    output result_t res
);

    localparam int CNT_W = $clog2((MAX_FRAME > LEN_POS) ? MAX_FRAME : LEN_POS + 1);
    localparam int TOT_W = $clog2((1 << BYTE_W) + LEN_POS + 3);
    localparam logic [TOT_W-1:0] LEN_OFS = TOT_W'(LEN_POS + 3);
    localparam logic [TOT_W-1:0] MAX_TOT = TOT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] LEN_AT  = CNT_W'(LEN_POS);

    state_t            state_reg,   state_next;
    logic [CNT_W-1:0]  count_reg,   count_next;
    logic [BYTE_W-1:0] sum_reg,     sum_next;
    logic [BYTE_W-1:0] decl_reg,    decl_next;
    logic              matched_reg, matched_next;
    logic [TICK_W-1:0] idle_reg,    idle_next;

    logic              is_tick;
    logic              is_sync;
    logic [TICK_W-1:0] idle_inc;
    logic              timed_out;
    logic [TOT_W-1:0]  len_total;
    logic [TOT_W-1:0]  frm_total;
    logic [TOT_W-1:0]  p_ext;
    logic              at_len;
    logic              past_len;
    logic              too_long;
    logic              at_sum;
    logic              at_last;
    logic              end_now;

    // shared decode
    assign is_tick   = (item.cmd == CMD_TICK);
    assign is_sync   = (item.rx_byte == cfg.sync_value);
    assign idle_inc  = idle_reg + 1'b1;
    assign timed_out = (idle_inc >= cfg.timeout_ticks);
    assign len_total = TOT_W'(item.rx_byte) + LEN_OFS;
    assign frm_total = TOT_W'(decl_reg) + LEN_OFS;
    assign p_ext     = TOT_W'(count_reg);
    assign at_len    = (count_reg == LEN_AT);
    assign past_len  = (count_reg > LEN_AT);
    assign too_long  = at_len && (len_total > MAX_TOT);
    assign at_sum    = past_len && ((p_ext + TOT_W'(2)) == frm_total);
    assign at_last   = past_len && !at_sum && ((p_ext + TOT_W'(1)) >= frm_total);
    assign end_now   = too_long || at_last;

    // next state
    always_comb begin
        state_next = state_reg;
        if (step) begin
            unique case (state_reg)
                ST_SYNC: begin
                    if (!is_tick && is_sync) begin
                        state_next = ST_FRAME;
                    end
                end
                ST_FRAME: begin
                    if (is_tick ? timed_out : end_now) begin
                        state_next = ST_SYNC;
                    end
                end
                default: state_next = ST_SYNC;
            endcase
        end
    end

    // result for the current beat
    always_comb begin
        res_valid       = 1'b0;
        res.data_byte   = item.rx_byte;
        res.position    = POS_W'(count_reg);
        res.frame_start = 1'b0;
        res.frame_end   = 1'b0;
        res.verdict     = VERDICT_NONE;
        unique case (state_reg)
            ST_SYNC: begin
                res_valid       = !is_tick && is_sync;
                res.position    = '0;
                res.frame_start = 1'b1;
            end
            ST_FRAME: begin
                if (is_tick) begin
                    res_valid     = timed_out;
                    res.data_byte = '0;
                    res.frame_end = 1'b1;
                    res.verdict   = VERDICT_TIMEOUT;
                end else begin
                    res_valid     = 1'b1;
                    res.frame_end = end_now;
                    priority if (too_long) begin
                        res.verdict = VERDICT_TOO_LONG;
                    end else if (at_last && !matched_reg) begin
                        res.verdict = VERDICT_SUM_BAD;
                    end else if (at_last && (item.rx_byte != cfg.end_value)) begin
                        res.verdict = VERDICT_END_BAD;
                    end else if (at_last) begin
                        res.verdict = VERDICT_GOOD;
                    end else begin
                        res.verdict = VERDICT_NONE;
                    end
                end
            end
            default: res_valid = 1'b0;
        endcase
    end

    // frame counters, running sum and idle timer
    always_comb begin
        count_next   = count_reg;
        sum_next     = sum_reg;
        decl_next    = decl_reg;
        matched_next = matched_reg;
        idle_next    = idle_reg;
        if (step) begin
            unique case (state_reg)
                ST_SYNC: begin
                    idle_next = '0;
                    if (!is_tick && is_sync) begin
                        count_next   = CNT_W'(1);
                        sum_next     = item.rx_byte;
                        decl_next    = '0;
                        matched_next = 1'b0;
                    end
                end
                ST_FRAME: begin
                    if (is_tick ? timed_out : end_now) begin
                        count_next   = '0;
                        sum_next     = '0;
                        decl_next    = '0;
                        matched_next = 1'b0;
                        idle_next    = '0;
                    end else if (is_tick) begin
                        idle_next = idle_inc;
                    end else begin
                        idle_next  = '0;
                        sum_next   = sum_reg + item.rx_byte;
                        count_next = count_reg + 1'b1;
                        if (at_len) begin
                            decl_next = item.rx_byte;
                        end
                        if (at_sum) begin
                            matched_next = (item.rx_byte == sum_reg);
                        end
                    end
                end
                default: count_next = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_SYNC;
            count_reg   <= '0;
            sum_reg     <= '0;
            decl_reg    <= '0;
            matched_reg <= 1'b0;
            idle_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            decl_reg    <= decl_next;
            matched_reg <= matched_next;
            idle_reg    <= idle_next;
        end
    end

    // checks on the frame tracking
    `MFR_ASSERT_NEXT(a_end_back_to_sync, step && res_valid && res.frame_end, state_reg == ST_SYNC, "frame end did not return to sync")
    `MFR_ASSERT_NEXT(a_start_opens_frame, step && res_valid && res.frame_start, (state_reg == ST_FRAME) && (count_reg == CNT_W'(1)), "frame start did not open a frame")
    `MFR_ASSERT_NOW(a_sync_cleared, state_reg == ST_SYNC, (count_reg == '0) && (idle_reg == '0), "counters not clear while waiting for sync")
    `MFR_ASSERT_NOW(a_frame_count_nonzero, state_reg == ST_FRAME, count_reg != '0, "byte count zero inside a frame")

endmodule

// File: hw/rtl/mfr_out_reg.sv
// result register stage of the meter frame receiver
module mfr_out_reg
    import mfr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  logic    res_valid,
    input  result_t res,
    output logic    out_free,
    output logic    m_tvalid,
    input  logic    m_tready,
    output result_t m_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // free when empty or when the held beat is taken this cycle
    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = step && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // payload capture
    always_ff @(posedge aclk) begin
        if (step && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_res    = res_reg;

endmodule

// File: hw/rtl/meter_frame_receiver_core.sv
// top level of the meter frame receiver
//
// Byte-serial receiver for meter frames. Each slave beat is either a received
// byte (s_tuser = 0, byte in s_tdata) or one time tick (s_tuser = 1). Once the
// sync byte arrives, every frame byte leaves on the master side with its offset
// in the frame; the final beat of a frame carries m_tlast and a verdict (good,
// checksum bad, end byte bad, timeout, too long). Bytes outside a frame and
// ticks that do not abort give no beat.
// The config channel writes sync value, end value and timeout (index 0..2). The user
// must write it only while no beat is in flight; the block itself does not enforce it.
// A result passes through the input register and then the result register before it
// is presented on m_tvalid; a low m_tready can hold it in either register.
// Throughput: one beat per cycle while m_tready stays high; the frame state update is
// compare, add and counter logic between the two registers.
// Reset (aresetn low, synchronous) restores the register defaults, drops any
// partial frame and empties both stages; s_tready and cfg_ready are low then.
// When m_tready is low the result register holds its beat and the input
// register still takes one more beat before s_tready drops.
module meter_frame_receiver_core
    import mfr_pkg::*;
#(
    parameter int LEN_POS   = LEN_POS_DEF,
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input beats
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic [0:0]            s_tuser,   // [0] cmd
    // result beats
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [7:0] data_byte, [15:8] position
    output logic                  m_tlast,
    output logic [3:0]            m_tuser,   // [0] frame_start, [3:1] verdict
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t    cfg;
    item_t   item;
    logic    item_valid;
    logic    out_free;
    logic    step;
    logic    res_valid;
    result_t res;
    result_t m_res;

    // a held input beat is processed when the result register has room
    assign step = item_valid && out_free;

    mfr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mfr_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    mfr_parser #(
        .LEN_POS   (LEN_POS),
        .MAX_FRAME (MAX_FRAME)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .step      (step),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    mfr_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_res     (m_res)
    );

    // result beat packing
    assign m_tdata = {m_res.position, m_res.data_byte};
    assign m_tlast = m_res.frame_end;
    assign m_tuser = {m_res.verdict, m_res.frame_start};

endmodule

// File: tb/sv/meter_frame_receiver_checker.sv
// result checker for the meter frame receiver: predicts every result beat and compares it
module meter_frame_receiver_checker
    import mfr_pkg::*;
#(
    parameter int LEN_POS   = LEN_POS_DEF,
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    input  logic [0:0]            s_tuser,   // [0] cmd
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,   // [7:0] data_byte, [15:8] position
    input  logic                  m_tlast,
    input  logic [3:0]            m_tuser,   // [0] frame_start, [3:1] verdict
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // register copy and frame tracking state
    cfg_t        regs;
    state_t      frame_state;
    logic [8:0]  byte_count;
    logic [7:0]  running_sum;
    logic [7:0]  declared_len;
    logic        sum_ok;
    logic [15:0] idle_count;

    result_t awaited_results[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want,
                               input int pos);
        if (got != want)
            report_mismatch($sformatf("%s got %0d want %0d (position %0d)",
                                      name, got, want, pos));
    endtask

    // back to hunting for the sync byte
    function automatic void drop_frame();
        frame_state  = ST_SYNC;
        byte_count   = '0;
        running_sum  = '0;
        declared_len = '0;
        sum_ok       = 1'b0;
        idle_count   = '0;
    endfunction

    // advance the frame state by one input beat; returns 1 when a result beat follows
    function automatic bit next_frame_result(input cmd_t cmd, input logic [7:0] rx,
                                             output result_t res);
        int unsigned offset;
        int unsigned frame_len;
        res = '0;
        res.verdict = VERDICT_NONE;

        // idle tick: counts only inside a frame, aborts at the limit
        if (cmd == CMD_TICK) begin
            if (frame_state == ST_SYNC) begin
                idle_count = '0;
                return 1'b0;
            end
            idle_count = idle_count + 16'd1;
            if (idle_count >= regs.timeout_ticks) begin
                res.position  = byte_count[7:0];
                res.frame_end = 1'b1;
                res.verdict   = VERDICT_TIMEOUT;
                drop_frame();
                return 1'b1;
            end
            return 1'b0;
        end

        // waiting for sync
        if (frame_state == ST_SYNC) begin
            if (rx != regs.sync_value) return 1'b0;
            drop_frame();
            frame_state     = ST_FRAME;
            running_sum     = rx;
            byte_count      = 9'd1;
            res.data_byte   = rx;
            res.frame_start = 1'b1;
            return 1'b1;
        end

        // byte inside a frame
        idle_count    = '0;
        offset        = byte_count;
        res.data_byte = rx;
        res.position  = offset[7:0];
        if (offset == LEN_POS) begin
            declared_len = rx;
            frame_len    = rx + LEN_POS + 3;
            if (frame_len > MAX_FRAME) begin
                res.frame_end = 1'b1;
                res.verdict   = VERDICT_TOO_LONG;
                drop_frame();
                return 1'b1;
            end
        end else if (offset > LEN_POS) begin
            frame_len = declared_len + LEN_POS + 3;
            if (offset + 2 == frame_len) begin
                sum_ok = (rx == running_sum);
            end else if (offset + 1 >= frame_len) begin
                res.frame_end = 1'b1;
                if (!sum_ok) res.verdict = VERDICT_SUM_BAD;
                else if (rx != regs.end_value) res.verdict = VERDICT_END_BAD;
                else res.verdict = VERDICT_GOOD;
                drop_frame();
                return 1'b1;
            end
        end
        running_sum = running_sum + rx;
        byte_count  = byte_count + 9'd1;
        return 1'b1;
    endfunction

    // watch all three channels at each edge
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        result_t fresh;
        if (!aresetn) begin
            regs.sync_value    = SYNC_RESET;
            regs.end_value     = END_RESET;
            regs.timeout_ticks = TIMEOUT_RESET;
            drop_frame();
            awaited_results.delete();
        end else begin
            // register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_SYNC:    regs.sync_value    = cfg_data[7:0];
                    REG_END:     regs.end_value     = cfg_data[7:0];
                    REG_TIMEOUT: regs.timeout_ticks = cfg_data[15:0];
                    default: ;
                endcase
            end

            // result beat against the oldest prediction
            if (m_tvalid && m_tready) begin
                got.data_byte   = m_tdata[7:0];
                got.position    = m_tdata[15:8];
                got.frame_start = m_tuser[0];
                got.frame_end   = m_tlast;
                got.verdict     = verdict_t'(m_tuser[3:1]);
                if (awaited_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result beat data %02h position %0d",
                                              got.data_byte, got.position));
                end else begin
                    want = awaited_results.pop_front();
                    check_field("data_byte", got.data_byte, want.data_byte, want.position);
                    check_field("position", got.position, want.position, want.position);
                    check_field("frame_start", got.frame_start, want.frame_start,
                                want.position);
                    check_field("frame_end", got.frame_end, want.frame_end, want.position);
                    check_field("verdict", got.verdict, want.verdict, want.position);
                end
            end

            // input beat
            if (s_tvalid && s_tready) begin
                if (next_frame_result(cmd_t'(s_tuser[0]), s_tdata, fresh))
                    awaited_results.push_back(fresh);
            end
        end
        pending <= awaited_results.size();
    end

endmodule

// File: tb/sv/meter_frame_receiver_core_test.sv
// top of the meter frame receiver testbench: clock, reset, frame stimulus and verdict
module meter_frame_receiver_core_test
    import mfr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEN_POS     = LEN_POS_DEF;
    localparam int MAX_FRAME   = MAX_FRAME_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_BEATS = 20;
    // longest tick run that is worth spending on an abort
    localparam int ABORT_MAX   = 50;

    typedef enum int {
        FRAME_CLEAN,
        FRAME_BAD_SUM,
        FRAME_BAD_END,
        FRAME_BAD_BOTH,
        FRAME_CUT
    } frame_fault_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata   = '0;   // [7:0] rx_byte
    logic [0:0]            s_tuser   = '0;   // [0] cmd
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [15:0]           m_tdata;          // [7:0] data_byte, [15:8] position
    logic                  m_tlast;
    logic [3:0]            m_tuser;          // [0] frame_start, [3:1] verdict
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SYNC;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;

    // stimulus-side view of the registers
    logic [7:0]  cfg_sync    = SYNC_RESET;
    logic [7:0]  cfg_end     = END_RESET;
    logic [15:0] cfg_timeout = TIMEOUT_RESET;

    int s_idle_pct  = 0;
    int m_stall_pct = 0;
    int frame_beats = 0;
    int quiet_cycles = 0;

    meter_frame_receiver_core #(
        .LEN_POS   (LEN_POS),
        .MAX_FRAME (MAX_FRAME)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    meter_frame_receiver_checker #(
        .LEN_POS   (LEN_POS),
        .MAX_FRAME (MAX_FRAME)
    ) frame_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // 8 ns clock
    always #4 aclk = ~aclk;

    // receiver back-pressure
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= m_stall_pct);
    end

    // watchdog: ends the run when no channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no beat accepted for %0d cycles", $time, QUIET_LIMIT);
            $display("meter_frame_receiver_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one input beat, with random sender gaps ahead of it
    task automatic send_beat(input cmd_t cmd, input logic [7:0] rx);
        while (s_idle_pct != 0 && $urandom_range(99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= rx;
        s_tuser  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // drain all results and let the pipeline empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // write all three registers back to back
    task automatic write_config(input logic [7:0] sync_v, input logic [7:0] end_v,
                                input logic [15:0] ticks);
        reg_index_t idx;
        logic [15:0] val;
        idx = idx.first();
        repeat (idx.num()) begin
            case (idx)
                REG_SYNC: val = {8'h00, sync_v};
                REG_END:  val = {8'h00, end_v};
                default:  val = ticks;
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            idx = idx.next();
        end
        cfg_valid   <= 1'b0;
        cfg_sync    = sync_v;
        cfg_end     = end_v;
        cfg_timeout = ticks;
    endtask

    // frame payload byte, now and then equal to the sync value
    function automatic logic [7:0] frame_byte();
        return ($urandom_range(7) == 0) ? cfg_sync : 8'($urandom);
    endfunction

    // mostly short frames, some long ones, some over the size limit
    function automatic int unsigned pick_len();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 80) return $urandom_range(12);
        if (roll < 90) return $urandom_range(243, 13);
        return $urandom_range(255, 244);
    endfunction

    function automatic frame_fault_t pick_fault();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70) return FRAME_CLEAN;
        if (roll < 78) return FRAME_BAD_SUM;
        if (roll < 86) return FRAME_BAD_END;
        if (roll < 90) return FRAME_BAD_BOTH;
        return (cfg_timeout <= ABORT_MAX) ? FRAME_CUT : FRAME_CLEAN;
    endfunction

    // enough ticks to abort a partial frame
    task automatic send_abort_ticks();
        repeat ((cfg_timeout == 0) ? 1 : int'(cfg_timeout))
            send_beat(CMD_TICK, 8'($urandom));
    endtask

    // noise between frames: ticks or bytes that are not sync
    task automatic send_noise();
        logic [7:0] rx;
        if ($urandom_range(1) == 0) begin
            send_beat(CMD_TICK, 8'($urandom));
        end else begin
            do rx = 8'($urandom); while (rx == cfg_sync);
            send_beat(CMD_BYTE, rx);
        end
    endtask

    // one frame with random content, optionally damaged
    task automatic send_frame(input int unsigned len, input frame_fault_t fault);
        logic [7:0] body[$];
        logic [7:0] csum;
        int unsigned stop;
        int unsigned room;
        body.push_back(cfg_sync);
        for (int i = 1; i < LEN_POS; i++) body.push_back(frame_byte());
        body.push_back(len[7:0]);
        if (len + LEN_POS + 3 <= MAX_FRAME) begin
            for (int i = 0; i < len; i++) body.push_back(frame_byte());
            csum = '0;
            foreach (body[i]) csum = csum + body[i];
            if (fault == FRAME_BAD_SUM || fault == FRAME_BAD_BOTH)
                csum = csum ^ 8'($urandom_range(255, 1));
            body.push_back(csum);
            if (fault == FRAME_BAD_END || fault == FRAME_BAD_BOTH)
                body.push_back(cfg_end ^ 8'($urandom_range(255, 1)));
            else
                body.push_back(cfg_end);
        end
        stop = (fault == FRAME_CUT) ? $urandom_range(body.size() - 1, 1) : body.size();
        room = (cfg_timeout > 1) ? cfg_timeout - 1 : 0;
        for (int i = 0; i < stop; i++) begin
            send_beat(CMD_BYTE, body[i]);
            frame_beats++;
            // short tick bursts inside the frame stay under the timeout
            if (room != 0 && i + 1 < stop && $urandom_range(19) == 0)
                repeat ($urandom_range((room < 6) ? room : 6, 1))
                    send_beat(CMD_TICK, 8'($urandom));
        end
        if (fault == FRAME_CUT) send_abort_ticks();
    endtask

    // sync, one byte, then silence until the frame is dropped
    task automatic send_stalled_frame();
        send_beat(CMD_BYTE, cfg_sync);
        send_beat(CMD_BYTE, frame_byte());
        send_abort_ticks();
    endtask

    task automatic send_random_frames(input int target);
        int start;
        start = frame_beats;
        while (frame_beats - start < target) begin
            repeat ($urandom_range(2)) send_noise();
            send_frame(pick_len(), pick_fault());
        end
    endtask

    task automatic run_phase(input logic [7:0] sync_v, input logic [7:0] end_v,
                             input logic [15:0] ticks, input int idle_pct,
                             input int stall_pct);
        settle();
        write_config(sync_v, end_v, ticks);
        s_idle_pct  = idle_pct;
        m_stall_pct = stall_pct;
        if (cfg_timeout <= ABORT_MAX) send_stalled_frame();
        send_random_frames(PHASE_BEATS);
    endtask

    // stimulus
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: register defaults, no idling
        send_beat(CMD_BYTE, 8'h00);
        send_beat(CMD_TICK, 8'hFF);
        send_frame(0, FRAME_CLEAN);
        send_frame(255, FRAME_CLEAN);
        if (cfg_timeout <= ABORT_MAX) send_stalled_frame();
        send_random_frames(PHASE_BEATS);

        // register extremes under each idling pattern
        run_phase(8'h00, 8'hFF, 16'd1, 80, 0);
        run_phase(8'hFF, 8'h00, 16'd0, 0, 80);
        run_phase(8'($urandom), 8'($urandom), 16'hFFFF, 31, 31);
        run_phase(8'($urandom), 8'($urandom), 16'($urandom_range(12, 2)), 0, 0);
        send_frame(MAX_FRAME - LEN_POS - 3, FRAME_CLEAN);
        run_phase(SYNC_RESET, END_RESET, 16'd40, 31, 31);

        settle();
        if (mismatches == 0)
            $display("meter_frame_receiver_core verification clean");
        else
            $display("meter_frame_receiver_core verification failed");
        $finish;
    end

endmodule
